FILE: hw/rtl/wlpm_pkg.sv
// Package: constants, codes and types shared by the window/level pixel mapper.
`timescale 1ns / 1ps
package wlpm_pkg;

	// Fixed-point format of the gain and the mapping product
	localparam int FRAC_BITS       = 16;
	localparam int SAMPLE_W        = 17;
	localparam int DIFF_W          = SAMPLE_W + 1;
	localparam int SCALE_W         = 24;
	localparam int PROD_W          = DIFF_W + SCALE_W + 1;
	localparam int BYTE_W          = 8;
	localparam int COUNT_W         = 3;

	// Palette
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int PAL_DW          = 4 * BYTE_W;

	// Configuration port
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = SCALE_W;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_BITS;
	localparam logic signed [PROD_W-1:0] LIMIT_TOP = PROD_W'(255) << FRAC_BITS;
	localparam logic [BYTE_W-1:0] BYTE_FULL = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LOW  = 3'd0,
		CFG_SCALE       = 3'd1,
		CFG_RENDER_MODE = 3'd2,
		CFG_COLOR_MODEL = 3'd3,
		CFG_USE_PALETTE = 3'd4
	} cfg_idx_t;

	// Render mode codes; the unused code behaves as limit clamp
	typedef enum logic [1:0] {
		MODE_LIMIT  = 2'd0,
		MODE_BINARY = 2'd1,
		MODE_MASK   = 2'd2
	} render_mode_t;

	typedef enum logic [1:0] {
		CM_INTENSITY       = 2'd0,
		CM_INTENSITY_ALPHA = 2'd1,
		CM_COLOUR          = 2'd2,
		CM_COLOUR_ALPHA    = 2'd3
	} color_model_t;

	// Request function codes
	localparam logic FUNC_MAP       = 1'b0;
	localparam logic FUNC_PAL_WRITE = 1'b1;

	// Classification of one channel product
	typedef struct packed {
		logic [BYTE_W-1:0] lim;   // truncated and clamped value
		logic              neg;   // product below zero
		logic              over;  // product above the window top
		logic              pos;   // product above zero
	} wlpm_cls_t;

endpackage

FILE: hw/rtl/wlpm_if.sv
// Interfaces: request and result channels of the pixel mapper.
`timescale 1ns / 1ps
interface wlpm_in_if import wlpm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [SAMPLE_W-1:0] sample_zero;
	logic signed [SAMPLE_W-1:0] sample_one;
	logic signed [SAMPLE_W-1:0] sample_two;
	logic signed [SAMPLE_W-1:0] sample_three;
	logic [PAL_AW-1:0]          palette_index;
	logic [PAL_DW-1:0]          palette_word;

	modport source (
		output valid, func, sample_zero, sample_one, sample_two, sample_three,
		       palette_index, palette_word,
		input  ready
	);
	modport sink (
		input  valid, func, sample_zero, sample_one, sample_two, sample_three,
		       palette_index, palette_word,
		output ready
	);
endinterface

interface wlpm_out_if import wlpm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  byte_zero;
	logic [BYTE_W-1:0]  byte_one;
	logic [BYTE_W-1:0]  byte_two;
	logic [BYTE_W-1:0]  byte_three;
	logic [COUNT_W-1:0] byte_count;

	modport source (
		output valid, byte_zero, byte_one, byte_two, byte_three, byte_count,
		input  ready
	);
	modport sink (
		input  valid, byte_zero, byte_one, byte_two, byte_three, byte_count,
		output ready
	);
endinterface

FILE: hw/rtl/wlpm_lane.sv
// One channel lane: window offset, gain multiply and clamp classification.
`timescale 1ns / 1ps
module wlpm_lane import wlpm_pkg::*; (
	input  logic                       clk,
	input  logic                       en_s2,
	input  logic                       en_s3,
	input  logic signed [SAMPLE_W-1:0] smp_s1,
	input  logic signed [SAMPLE_W-1:0] window_low,
	input  logic [SCALE_W-1:0]         scale,
	output logic [BYTE_W-1:0]          lim_nxt,
	output wlpm_cls_t                  cls_s3
);

	logic signed [DIFF_W-1:0]  diff;
	logic signed [SCALE_W:0]   gain;
	logic signed [PROD_W-1:0]  prod_s2;
	wlpm_cls_t                 cls_nxt;

	// Offset by the window bottom, then the gain product
	assign diff = DIFF_W'(smp_s1) - DIFF_W'(window_low);
	assign gain = $signed({1'b0, scale});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= PROD_W'(diff) * PROD_W'(gain);
		end
	end

	// Clamp to one byte, keep the flags for binary, mask and alpha
	always_comb begin
		cls_nxt.neg  = prod_s2[PROD_W-1];
		cls_nxt.over = prod_s2 > LIMIT_TOP;
		cls_nxt.pos  = !cls_nxt.neg && (prod_s2 != '0);
		if (cls_nxt.neg) begin
			cls_nxt.lim = '0;
		end else if (cls_nxt.over) begin
			cls_nxt.lim = BYTE_FULL;
		end else begin
			cls_nxt.lim = prod_s2[FRAC_BITS +: BYTE_W];
		end
	end

	assign lim_nxt = cls_nxt.lim;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cls_s3 <= cls_nxt;
		end
	end

endmodule

FILE: hw/rtl/wlpm_palette.sv
// Palette store: single-port colour table with registered read data.
`timescale 1ns / 1ps
module wlpm_palette import wlpm_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [PAL_AW-1:0] addr,
	input  logic [PAL_DW-1:0] wdata,
	output logic [PAL_DW-1:0] rdata_q
);

	logic [PAL_DW-1:0] mem [PALETTE_ENTRIES];

	// Write or read, one access a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

FILE: hw/rtl/window_level_pixel_mapper.sv
// Top level: window/level pixel mapper with palette and colour models.
//
//  channel | dir | handshake      | carries
//  --------+-----+----------------+-------------------------------------------
//  req     | in  | valid/ready    | func, four samples, palette index and word
//  res     | out | valid/ready    | four bytes and byte count, one per map
//  cfg     | in  | cfg_we         | register index and data, no read-back
//
//  One request a cycle while the stages have room; a result is offered from the result register.
//  Stages: input register, product register, classify plus palette read,
//  result register. Each stage moves on when the next has room, so bubbles
//  close up and requests are taken while a result waits.
//  Palette writes use the table port in request order and give no result.
//  Reset clears the stage valid bits and the configuration registers; the
//  palette and the stage data registers are not cleared.
`timescale 1ns / 1ps
module window_level_pixel_mapper import wlpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wlpm_in_if.sink               req,
	wlpm_out_if.source            res
);

	// Configuration registers
	logic signed [SAMPLE_W-1:0] window_low_q;
	logic [SCALE_W-1:0]         scale_q;
	logic [1:0]                 render_mode_q;
	logic [1:0]                 color_model_q;
	logic                       use_palette_q;

	// Stage control
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic out_free, free3, free2, free1;
	logic en_s1, en_s2, en_s3, load_out;

	// Stage payload
	logic signed [SAMPLE_W-1:0] smp_s1 [4];
	logic                       func_s1, func_s2, func_s3;
	logic [PAL_AW-1:0]          pidx_s1, pidx_s2;
	logic [PAL_DW-1:0]          pword_s1, pword_s2;
	logic [BYTE_W-1:0]          lim_nxt [4];
	wlpm_cls_t                  cls_s3 [4];
	logic [PAL_DW-1:0]          pal_s3;
	logic                       pal_re, pal_we;
	logic [PAL_AW-1:0]          pal_addr;

	// Result
	logic [BYTE_W-1:0]  b_nxt [4];
	logic [BYTE_W-1:0]  b_int;
	logic               is_limit;
	logic [BYTE_W-1:0]  byte_q [4];
	logic [COUNT_W-1:0] count_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= '0;
			scale_q       <= SCALE_RESET;
			render_mode_q <= MODE_LIMIT;
			color_model_q <= CM_INTENSITY;
			use_palette_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WINDOW_LOW:  window_low_q  <= $signed(cfg_data[SAMPLE_W-1:0]);
				CFG_SCALE:       scale_q       <= cfg_data[SCALE_W-1:0];
				CFG_RENDER_MODE: render_mode_q <= cfg_data[1:0];
				CFG_COLOR_MODEL: color_model_q <= cfg_data[1:0];
				CFG_USE_PALETTE: use_palette_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage advance: palette writes drop out at stage three
	assign out_free  = !out_valid_q || res.ready;
	assign free3     = !v3_s3 || (func_s3 == FUNC_PAL_WRITE) || out_free;
	assign free2     = !v2_s2 || free3;
	assign free1     = !v1_s1 || free2;
	assign req.ready = free1;
	assign en_s1     = req.valid && free1;
	assign en_s2     = v1_s1 && free2;
	assign en_s3     = v2_s2 && free3;
	assign load_out  = v3_s3 && (func_s3 == FUNC_MAP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v1_s1       <= en_s1 || (v1_s1 && !free2);
			v2_s2       <= en_s2 || (v2_s2 && !free3);
			v3_s3       <= en_s3 || (v3_s3 && !free3);
			out_valid_q <= load_out || (out_valid_q && !res.ready);
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			func_s1   <= req.func;
			smp_s1[0] <= req.sample_zero;
			smp_s1[1] <= req.sample_one;
			smp_s1[2] <= req.sample_two;
			smp_s1[3] <= req.sample_three;
			pidx_s1   <= req.palette_index;
			pword_s1  <= req.palette_word;
		end
	end

	// Palette write fields and function follow the lanes
	always_ff @(posedge clk) begin
		if (en_s2) begin
			func_s2  <= func_s1;
			pidx_s2  <= pidx_s1;
			pword_s2 <= pword_s1;
		end
		if (en_s3) begin
			func_s3 <= func_s2;
		end
	end

	// Four channel lanes
	for (genvar k = 0; k < 4; k++) begin : g_lane
		wlpm_lane u_lane (
			.clk        (clk),
			.en_s2      (en_s2),
			.en_s3      (en_s3),
			.smp_s1     (smp_s1[k]),
			.window_low (window_low_q),
			.scale      (scale_q),
			.lim_nxt    (lim_nxt[k]),
			.cls_s3     (cls_s3[k])
		);
	end

	// Palette: write entry or look up by clamped channel zero
	assign pal_we   = en_s3 && (func_s2 == FUNC_PAL_WRITE);
	assign pal_re   = en_s3 && (func_s2 == FUNC_MAP);
	assign pal_addr = (func_s2 == FUNC_PAL_WRITE) ? pidx_s2 : lim_nxt[0];

	wlpm_palette u_palette (
		.clk     (clk),
		.we      (pal_we),
		.re      (pal_re),
		.addr    (pal_addr),
		.wdata   (pword_s2),
		.rdata_q (pal_s3)
	);

	// Byte selection for the render mode and colour model
	always_comb begin
		b_nxt[0] = '0;
		b_nxt[1] = '0;
		b_nxt[2] = '0;
		b_nxt[3] = '0;
		case (render_mode_q)
			MODE_BINARY: b_int = cls_s3[0].neg ? '0 : BYTE_FULL;
			MODE_MASK:   b_int = (cls_s3[0].neg || cls_s3[0].over) ? '0 : BYTE_FULL;
			default:     b_int = cls_s3[0].lim;
		endcase
		is_limit = !(render_mode_q == MODE_BINARY || render_mode_q == MODE_MASK);
		unique case (color_model_q) inside
			CM_INTENSITY: begin
				b_nxt[0] = b_int;
			end
			CM_INTENSITY_ALPHA: begin
				b_nxt[0] = b_int;
				if (render_mode_q == MODE_MASK) begin
					b_nxt[1] = b_int;
				end else begin
					b_nxt[1] = cls_s3[0].pos ? BYTE_FULL : '0;
				end
			end
			CM_COLOUR, CM_COLOUR_ALPHA: begin
				if (is_limit) begin
					for (int k = 0; k < 3; k++) begin
						b_nxt[k] = use_palette_q ? pal_s3[k*BYTE_W +: BYTE_W]
						                         : cls_s3[k].lim;
					end
					if (color_model_q == CM_COLOUR_ALPHA) begin
						b_nxt[3] = use_palette_q ? pal_s3[3*BYTE_W +: BYTE_W]
						                         : cls_s3[3].lim;
					end
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int k = 0; k < 4; k++) begin
				byte_q[k] <= b_nxt[k];
			end
			count_q <= COUNT_W'(color_model_q) + COUNT_W'(1);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.byte_zero  = byte_q[0];
	assign res.byte_one   = byte_q[1];
	assign res.byte_two   = byte_q[2];
	assign res.byte_three = byte_q[3];
	assign res.byte_count = count_q;

endmodule

FILE: hw/rtl/wlpm_checker.sv
// Checker: result channel rules of the pixel mapper, bound to the top level.
`timescale 1ns / 1ps
module wlpm_checker import wlpm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               valid,
	input logic               ready,
	input logic [BYTE_W-1:0]  byte_one,
	input logic [BYTE_W-1:0]  byte_two,
	input logic [BYTE_W-1:0]  byte_three,
	input logic [COUNT_W-1:0] byte_count
);

	// A stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its count
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(byte_count))
		else $error("result count changed while stalled");

	// Count is one to four
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (byte_count != 3'd0) && (byte_count <= 3'd4))
		else $error("byte count out of range");

	// Bytes past the count are zero, checked for counts of one and three
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (byte_count == 3'd1) |->
			(byte_one == '0) && (byte_two == '0) && (byte_three == '0))
		else $error("unused bytes not zero for intensity");

	a_unused_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (byte_count == 3'd3) |-> (byte_three == '0))
		else $error("unused alpha byte not zero for colour");

endmodule

bind window_level_pixel_mapper wlpm_checker u_wlpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (res.valid),
	.ready      (res.ready),
	.byte_one   (res.byte_one),
	.byte_two   (res.byte_two),
	.byte_three (res.byte_three),
	.byte_count (res.byte_count)
);
